// File: design/cpo_pkg.sv
package cpo_pkg;

    localparam int SqrtSteps = 32;
    localparam int QuoBits   = 33;
    localparam int Lanes     = 4;
    localparam int Q14Shift  = 14;

    // Per-pair context carried alongside the arithmetic pipeline.
    typedef struct packed {
        logic signed [31:0] x1;
        logic signed [31:0] y1;
        logic signed [31:0] x2;
        logic signed [31:0] y2;
        logic signed [32:0] dx;
        logic signed [32:0] dy;
        logic        [30:0] adx;
        logic        [30:0] ady;
        logic        [30:0] rsum;
        logic        [4:0]  sh;
        logic        [31:0] d;
        logic               far;
        logic               hit;
        logic               coinc;
        logic               k1;
        logic               k2;
    } t_side;

endpackage

// File: design/cpo_if.sv
interface cpo_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] first_x;
    logic signed [31:0] first_y;
    logic        [29:0] first_radius;
    logic               first_kinetic;
    logic signed [31:0] second_x;
    logic signed [31:0] second_y;
    logic        [29:0] second_radius;
    logic               second_kinetic;

    modport source(output valid, first_x, first_y, first_radius, first_kinetic,
                   second_x, second_y, second_radius, second_kinetic, input ready);
    modport sink(input valid, first_x, first_y, first_radius, first_kinetic,
                 second_x, second_y, second_radius, second_kinetic, output ready);
endinterface

interface cpo_out_if;
    logic               valid;
    logic               ready;
    logic               collided;
    logic signed [31:0] new_first_x;
    logic signed [31:0] new_first_y;
    logic signed [31:0] new_second_x;
    logic signed [31:0] new_second_y;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;

    modport source(output valid, collided, new_first_x, new_first_y, new_second_x,
                   new_second_y, normal_x, normal_y, input ready);
    modport sink(input valid, collided, new_first_x, new_first_y, new_second_x,
                 new_second_y, normal_x, normal_y, output ready);
endinterface

// File: design/circle_pair_overlap_separation.sv
// Path: the input stages feed the 32-stage square root and then the 33-stage
// rounding dividers before the output register.
// Throughput: one pair per cycle; the whole pipeline holds while the output
// register is full and not taken.
// Reset: synchronous active-low i_rst_n clears all valid bits; data
// registers are not reset.
module circle_pair_overlap_separation
    import cpo_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    cpo_in_if.sink    i_in,
    cpo_out_if.source o_out
);

    typedef struct packed {
        logic [63:0] s;
        logic [4:0]  sh;
    } t_nrm;

    function automatic t_nrm norm_step(t_nrm a, int k, int thr);
        t_nrm b;
        b = a;
        if (a.s < (64'd1 << thr)) begin
            b.s  = a.s << (2 * k);
            b.sh = a.sh + k[4:0];
        end
        return b;
    endfunction

    function automatic logic signed [31:0] sat32(logic signed [34:0] v);
        logic signed [31:0] r;
        if (v[34:31] == 4'b0000 || v[34:31] == 4'b1111) r = v[31:0];
        else if (v[34])                                  r = 32'sh8000_0000;
        else                                             r = 32'sh7fff_ffff;
        return r;
    endfunction

    logic en;
    logic r_ovld;
    assign en         = !r_ovld || o_out.ready;
    assign i_in.ready = en;

    // stage 1: differences
    t_side r_s1;
    logic  r_v1;
    // stage 2: squares
    t_side r_s2;
    logic  r_v2;
    logic [61:0] r_sqx, r_sqy, r_rr;
    // stage 3: distance squared, hit test
    t_side r_s3;
    logic  r_v3;
    logic [62:0] r_ss;
    // stages 4-6: normalization
    t_side r_s4, r_s5, r_s6;
    logic  r_v4, r_v5, r_v6;
    t_nrm  r_n4, r_n5, r_n6;

    logic [32:0] magx, magy;
    t_nrm n_n4, n_n5, n_n6, n3;
    t_side n_s1, n_s2, n_s3, n_s6;

    assign magx = r_s1.dx[32] ? 33'(-r_s1.dx) : 33'(r_s1.dx);
    assign magy = r_s1.dy[32] ? 33'(-r_s1.dy) : 33'(r_s1.dy);
    assign n3   = '{s: {1'b0, r_ss}, sh: 5'd0};

    always_comb begin
        n_n4 = norm_step(norm_step(n3, 16, 28), 8, 44);
        n_n5 = norm_step(norm_step(r_n4, 4, 52), 2, 56);
        n_n6 = norm_step(norm_step(r_n5, 1, 58), 1, 60);
    end

    always_comb begin
        n_s1      = '0;
        n_s1.x1   = i_in.first_x;
        n_s1.y1   = i_in.first_y;
        n_s1.x2   = i_in.second_x;
        n_s1.y2   = i_in.second_y;
        n_s1.dx   = 33'(i_in.second_x) - 33'(i_in.first_x);
        n_s1.dy   = 33'(i_in.second_y) - 33'(i_in.first_y);
        n_s1.rsum = {1'b0, i_in.first_radius} + {1'b0, i_in.second_radius};
        n_s1.k1   = i_in.first_kinetic;
        n_s1.k2   = i_in.second_kinetic;

        n_s2      = r_s1;
        n_s2.adx  = magx[30:0];
        n_s2.ady  = magy[30:0];
        n_s2.far  = magx[32] | magx[31] | magy[32] | magy[31];

        n_s3       = r_s2;
        n_s3.hit   = !r_s2.far && ({1'b0, r_rr} > ({1'b0, r_sqx} + {1'b0, r_sqy}));
        n_s3.coinc = (r_sqx == '0) && (r_sqy == '0);

        n_s6    = r_s5;
        n_s6.sh = n_n6.sh;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1       <= n_s1;

            r_s2       <= n_s2;
            r_sqx      <= magx[30:0] * magx[30:0];
            r_sqy      <= magy[30:0] * magy[30:0];
            r_rr       <= r_s1.rsum * r_s1.rsum;

            r_s3       <= n_s3;
            r_ss       <= {1'b0, r_sqx} + {1'b0, r_sqy};

            r_s4 <= r_s3;
            r_n4 <= n_n4;
            r_s5 <= r_s4;
            r_n5 <= n_n5;
            r_s6 <= n_s6;
            r_n6 <= n_n6;
        end
    end

    logic [31:0] sq_root;
    t_side       sq_side;
    logic        sq_vld;

    cpo_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_vld  (r_v6),
        .i_rad  (r_n6.s),
        .i_side (r_s6),
        .o_vld  (sq_vld),
        .o_root (sq_root),
        .o_side (sq_side)
    );

    // stage 7: overlap and normal numerators
    t_side r_s7;
    logic  r_v7;
    logic [61:0] r_ov;
    logic [63:0] r_nmx7, r_nmy7;
    // stage 8: partial products of the push numerators
    t_side r_s8;
    logic  r_v8;
    logic [61:0] r_pxl, r_pxh, r_pyl, r_pyh;
    logic [63:0] r_nmx8, r_nmy8;
    // stage 9: divider operands
    t_side r_s9;
    logic  r_v9;
    logic [63:0] r_num [0:Lanes-1];

    logic [61:0] ov_diff;
    t_side       n_s7;
    assign ov_diff = (62'(sq_side.rsum) << sq_side.sh) - 62'(sq_root);

    always_comb begin
        n_s7   = sq_side;
        n_s7.d = sq_root;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s7   <= n_s7;
            r_ov   <= (sq_side.hit && !sq_side.coinc) ? ov_diff : '0;
            r_nmx7 <= (64'(sq_side.adx) << sq_side.sh) << Q14Shift;
            r_nmy7 <= (64'(sq_side.ady) << sq_side.sh) << Q14Shift;

            r_s8   <= r_s7;
            r_pxl  <= r_s7.adx * r_ov[30:0];
            r_pxh  <= r_s7.adx * r_ov[61:31];
            r_pyl  <= r_s7.ady * r_ov[30:0];
            r_pyh  <= r_s7.ady * r_ov[61:31];
            r_nmx8 <= r_nmx7;
            r_nmy8 <= r_nmy7;

            r_s9     <= r_s8;
            r_num[0] <= 64'(r_pxl) + (64'(r_pxh) << 31);
            r_num[1] <= 64'(r_pyl) + (64'(r_pyh) << 31);
            r_num[2] <= r_nmx8;
            r_num[3] <= r_nmy8;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0; r_v2 <= 1'b0; r_v3 <= 1'b0; r_v4 <= 1'b0;
            r_v5 <= 1'b0; r_v6 <= 1'b0; r_v7 <= 1'b0; r_v8 <= 1'b0;
            r_v9 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_in.valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
            r_v7 <= sq_vld;
            r_v8 <= r_v7;
            r_v9 <= r_v8;
        end
    end

    logic [QuoBits-1:0] quo [0:Lanes-1];
    t_side              dv_side;
    logic               dv_vld;

    cpo_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_vld  (r_v9),
        .i_num  (r_num),
        .i_side (r_s9),
        .o_vld  (dv_vld),
        .o_quo  (quo),
        .o_side (dv_side)
    );

    // output stage: apply signs, split push, saturate
    logic                move;
    logic [QuoBits-1:0]  magpx, magpy;
    logic signed [33:0]  px, py;
    logic signed [15:0]  nx, ny;

    always_comb begin
        move  = dv_side.hit && !dv_side.coinc;
        magpx = (dv_side.k1 && dv_side.k2) ? (quo[0] >> 1) : quo[0];
        magpy = (dv_side.k1 && dv_side.k2) ? (quo[1] >> 1) : quo[1];
        px = '0;
        py = '0;
        nx = '0;
        ny = '0;
        if (move) begin
            px = dv_side.dx[32] ? -$signed({1'b0, magpx}) : $signed({1'b0, magpx});
            py = dv_side.dy[32] ? -$signed({1'b0, magpy}) : $signed({1'b0, magpy});
            nx = dv_side.dx[32] ? 16'(-quo[2]) : 16'(quo[2]);
            ny = dv_side.dy[32] ? 16'(-quo[3]) : 16'(quo[3]);
        end
    end

    logic               r_col;
    logic signed [31:0] r_x1, r_y1, r_x2, r_y2;
    logic signed [15:0] r_nx, r_ny;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (en) begin
            r_ovld <= dv_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_col <= dv_side.hit;
            r_nx  <= nx;
            r_ny  <= ny;
            r_x1  <= dv_side.k1 ? sat32(35'(dv_side.x1) - 35'(px)) : dv_side.x1;
            r_y1  <= dv_side.k1 ? sat32(35'(dv_side.y1) - 35'(py)) : dv_side.y1;
            r_x2  <= dv_side.k2 ? sat32(35'(dv_side.x2) + 35'(px)) : dv_side.x2;
            r_y2  <= dv_side.k2 ? sat32(35'(dv_side.y2) + 35'(py)) : dv_side.y2;
        end
    end

    assign o_out.valid        = r_ovld;
    assign o_out.collided     = r_col;
    assign o_out.new_first_x  = r_x1;
    assign o_out.new_first_y  = r_y1;
    assign o_out.new_second_x = r_x2;
    assign o_out.new_second_y = r_y2;
    assign o_out.normal_x     = r_nx;
    assign o_out.normal_y     = r_ny;

    a_nocol_zero_normal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.collided |-> o_out.normal_x == '0 && o_out.normal_y == '0)
        else $error("normal nonzero without collision");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> o_out.valid)
        else $error("input stalled with empty output register");

    a_normal_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> o_out.normal_x <= 16'sd16384 && o_out.normal_x >= -16'sd16384)
        else $error("normal x out of unit range");

endmodule

// File: design/cpo_sqrt.sv
module cpo_sqrt
    import cpo_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_vld,
    input  logic [63:0] i_rad,
    input  t_side       i_side,
    output logic        o_vld,
    output logic [31:0] o_root,
    output t_side       o_side
);

    logic [63:0] r_v    [0:SqrtSteps];
    logic [33:0] r_rem  [0:SqrtSteps];
    logic [31:0] r_root [0:SqrtSteps];
    t_side       r_side [0:SqrtSteps];
    logic        r_vld  [0:SqrtSteps];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i <= SqrtSteps; i++) r_vld[i] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_vld;
            for (int i = 0; i < SqrtSteps; i++) r_vld[i+1] <= r_vld[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_v[0]    <= i_rad;
            r_rem[0]  <= '0;
            r_root[0] <= '0;
            r_side[0] <= i_side;
        end
    end

    // One root bit per stage, two radicand bits shifted in each time.
    for (genvar j = 0; j < SqrtSteps; j++) begin : g_step
        logic [35:0] cat;
        logic [35:0] trial;
        assign cat   = {r_rem[j], r_v[j][63:62]};
        assign trial = {2'b00, r_root[j], 2'b01};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_v[j+1]    <= {r_v[j][61:0], 2'b00};
                r_side[j+1] <= r_side[j];
                if (cat >= trial) begin
                    r_rem[j+1]  <= 34'(cat - trial);
                    r_root[j+1] <= {r_root[j][30:0], 1'b1};
                end else begin
                    r_rem[j+1]  <= cat[33:0];
                    r_root[j+1] <= {r_root[j][30:0], 1'b0};
                end
            end
        end
    end

    assign o_vld  = r_vld[SqrtSteps];
    assign o_root = r_root[SqrtSteps];
    assign o_side = r_side[SqrtSteps];

endmodule

// File: design/cpo_div.sv
module cpo_div
    import cpo_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_vld,
    input  logic [63:0]          i_num [0:Lanes-1],
    input  t_side                i_side,
    output logic                 o_vld,
    output logic [QuoBits-1:0]   o_quo [0:Lanes-1],
    output t_side                o_side
);

    // Rounded quotient (num + den/2) / den; den is i_side.d, num < den * 2^32.
    logic [31:0]        r_rem [0:QuoBits][0:Lanes-1];
    logic [QuoBits-1:0] r_nb  [0:QuoBits][0:Lanes-1];
    logic [QuoBits-1:0] r_q   [0:QuoBits][0:Lanes-1];
    t_side              r_side[0:QuoBits];
    logic               r_vld [0:QuoBits];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i <= QuoBits; i++) r_vld[i] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_vld;
            for (int i = 0; i < QuoBits; i++) r_vld[i+1] <= r_vld[i];
        end
    end

    for (genvar l = 0; l < Lanes; l++) begin : g_lane
        logic [63:0] biased;
        assign biased = i_num[l] + {33'd0, i_side.d[31:1]};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[0][l] <= {1'b0, biased[63:QuoBits]};
                r_nb[0][l]  <= biased[QuoBits-1:0];
                r_q[0][l]   <= '0;
            end
        end
        for (genvar j = 0; j < QuoBits; j++) begin : g_step
            logic [32:0] cat;
            assign cat = {r_rem[j][l], r_nb[j][l][QuoBits-1]};
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_nb[j+1][l] <= {r_nb[j][l][QuoBits-2:0], 1'b0};
                    if (cat >= {1'b0, r_side[j].d}) begin
                        r_rem[j+1][l] <= 32'(cat - {1'b0, r_side[j].d});
                        r_q[j+1][l]   <= {r_q[j][l][QuoBits-2:0], 1'b1};
                    end else begin
                        r_rem[j+1][l] <= cat[31:0];
                        r_q[j+1][l]   <= {r_q[j][l][QuoBits-2:0], 1'b0};
                    end
                end
            end
        end
        assign o_quo[l] = r_q[QuoBits][l];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= i_side;
            for (int i = 0; i < QuoBits; i++) r_side[i+1] <= r_side[i];
        end
    end

    assign o_vld  = r_vld[QuoBits];
    assign o_side = r_side[QuoBits];

endmodule
